/* sv/tkse_pkg.sv */
// Shared types, byte constants and key tables of the terminal key sequence encoder.
package tkse_pkg;

    // Request kinds.
    localparam logic [1:0] REQ_CHAR        = 2'd0;
    localparam logic [1:0] REQ_KEY         = 2'd1;
    localparam logic [1:0] REQ_PASTE_START = 2'd2;
    localparam logic [1:0] REQ_PASTE_END   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NEWLINE  = 2'd0;
    localparam logic [1:0] CFG_CURSOR   = 2'd1;
    localparam logic [1:0] CFG_KEYPAD   = 2'd2;
    localparam logic [1:0] CFG_BRACKET  = 2'd3;

    // Key table entry kinds.
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_LIT    = 3'd1;
    localparam logic [2:0] KIND_TAB    = 3'd2;
    localparam logic [2:0] KIND_ENTER  = 3'd3;
    localparam logic [2:0] KIND_SS3    = 3'd4;
    localparam logic [2:0] KIND_CSINUM = 3'd5;
    localparam logic [2:0] KIND_CURSOR = 3'd6;

    // Keypad key code range.
    localparam logic [5:0] KEYPAD_FIRST = 6'd28;
    localparam logic [5:0] KEYPAD_LAST  = 6'd45;

    // Bytes used in the generated sequences.
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [20:0] CTRL_MASK = 21'h1F;

    // Number of head and tail bytes a plan can hold.
    localparam int HEAD_BYTES = 5;
    localparam int TAIL_BYTES = 3;
    localparam int DEC_DIGITS = 7;

    // Multiples d * 10^k of every decimal place: entry [k][d-1].
    localparam logic [23:0] DEC_THRESH [DEC_DIGITS][9] = '{
        '{24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6, 24'd7, 24'd8, 24'd9},
        '{24'd10, 24'd20, 24'd30, 24'd40, 24'd50, 24'd60, 24'd70, 24'd80, 24'd90},
        '{24'd100, 24'd200, 24'd300, 24'd400, 24'd500, 24'd600, 24'd700, 24'd800,
          24'd900},
        '{24'd1000, 24'd2000, 24'd3000, 24'd4000, 24'd5000, 24'd6000, 24'd7000,
          24'd8000, 24'd9000},
        '{24'd10000, 24'd20000, 24'd30000, 24'd40000, 24'd50000, 24'd60000,
          24'd70000, 24'd80000, 24'd90000},
        '{24'd100000, 24'd200000, 24'd300000, 24'd400000, 24'd500000, 24'd600000,
          24'd700000, 24'd800000, 24'd900000},
        '{24'd1000000, 24'd2000000, 24'd3000000, 24'd4000000, 24'd5000000,
          24'd6000000, 24'd7000000, 24'd8000000, 24'd9000000}
    };

    typedef struct packed {
        logic newline;
        logic cursor_app;
        logic keypad_app;
        logic bracketed;
    } cfg_t;

    // One event's byte sequence: literal head, optional decimal number, literal tail.
    typedef struct packed {
        logic [HEAD_BYTES-1:0][7:0] head;
        logic [2:0]                 head_len;
        logic                       num_en;
        logic [20:0]                num_val;
        logic [2:0]                 num_top;
        logic [TAIL_BYTES-1:0][7:0] tail;
        logic [1:0]                 tail_len;
    } plan_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic [7:0] num;
    } key_entry_t;

    // Editing and function keys.
    function automatic key_entry_t key_lookup(input logic [5:0] key);
        key_entry_t e;
        e = '{KIND_NONE, 8'h00, 8'd0};
        unique case (key)
            6'd1:  e = '{KIND_ENTER, CH_CR, 8'd0};
            6'd2:  e = '{KIND_TAB, CH_TAB, 8'd0};
            6'd3:  e = '{KIND_LIT, CH_DEL, 8'd0};
            6'd4:  e = '{KIND_LIT, CH_ESC, 8'd0};
            6'd5:  e = '{KIND_CURSOR, 8'h41, 8'd0};
            6'd6:  e = '{KIND_CURSOR, 8'h42, 8'd0};
            6'd7:  e = '{KIND_CURSOR, 8'h44, 8'd0};
            6'd8:  e = '{KIND_CURSOR, 8'h43, 8'd0};
            6'd9:  e = '{KIND_CSINUM, CH_TILDE, 8'd2};
            6'd10: e = '{KIND_CSINUM, CH_TILDE, 8'd3};
            6'd11: e = '{KIND_CURSOR, 8'h48, 8'd0};
            6'd12: e = '{KIND_CURSOR, 8'h46, 8'd0};
            6'd13: e = '{KIND_CSINUM, CH_TILDE, 8'd5};
            6'd14: e = '{KIND_CSINUM, CH_TILDE, 8'd6};
            6'd16: e = '{KIND_SS3, 8'h50, 8'd0};
            6'd17: e = '{KIND_SS3, 8'h51, 8'd0};
            6'd18: e = '{KIND_SS3, 8'h52, 8'd0};
            6'd19: e = '{KIND_SS3, 8'h53, 8'd0};
            6'd20: e = '{KIND_CSINUM, CH_TILDE, 8'd15};
            6'd21: e = '{KIND_CSINUM, CH_TILDE, 8'd17};
            6'd22: e = '{KIND_CSINUM, CH_TILDE, 8'd18};
            6'd23: e = '{KIND_CSINUM, CH_TILDE, 8'd19};
            6'd24: e = '{KIND_CSINUM, CH_TILDE, 8'd20};
            6'd25: e = '{KIND_CSINUM, CH_TILDE, 8'd21};
            6'd26: e = '{KIND_CSINUM, CH_TILDE, 8'd23};
            6'd27: e = '{KIND_CSINUM, CH_TILDE, 8'd24};
            default: e = '{KIND_NONE, 8'h00, 8'd0};
        endcase
        return e;
    endfunction

    // Keypad byte, numeric or application form.
    function automatic logic [7:0] keypad_char(input logic [5:0] key, input logic app);
        logic [7:0] n;
        logic [7:0] a;
        n = 8'h30;
        a = 8'h70;
        unique case (key)
            6'd28: begin n = 8'h30; a = 8'h70; end
            6'd29: begin n = 8'h31; a = 8'h71; end
            6'd30: begin n = 8'h32; a = 8'h72; end
            6'd31: begin n = 8'h33; a = 8'h73; end
            6'd32: begin n = 8'h34; a = 8'h74; end
            6'd33: begin n = 8'h35; a = 8'h75; end
            6'd34: begin n = 8'h36; a = 8'h76; end
            6'd35: begin n = 8'h37; a = 8'h77; end
            6'd36: begin n = 8'h38; a = 8'h78; end
            6'd37: begin n = 8'h39; a = 8'h79; end
            6'd38: begin n = 8'h2A; a = 8'h6A; end
            6'd39: begin n = 8'h2B; a = 8'h6B; end
            6'd40: begin n = 8'h2C; a = 8'h6C; end
            6'd41: begin n = 8'h2D; a = 8'h6D; end
            6'd42: begin n = 8'h2E; a = 8'h6E; end
            6'd43: begin n = 8'h2F; a = 8'h6F; end
            6'd44: begin n = CH_LF; a = 8'h4D; end
            6'd45: begin n = 8'h3D; a = 8'h58; end
            default: begin n = 8'h30; a = 8'h70; end
        endcase
        return app ? a : n;
    endfunction

endpackage

/* sv/tkse_encoder.sv */
// Combinational encoder that turns one event into a head/number/tail byte plan.
module tkse_encoder (
    input  logic [1:0]          req_type,
    input  logic [20:0]         code_point,
    input  logic [5:0]          key_code,
    input  logic [2:0]          modifier,
    input  tkse_pkg::cfg_t      cfg,
    output tkse_pkg::plan_t     plan
);

    function automatic logic [7:0] mod_digit(input logic [2:0] m);
        return tkse_pkg::CH_ONE + {5'b0, m};
    endfunction

    // ESC [ value ; mod+1 u
    function automatic tkse_pkg::plan_t csi_u(input logic [20:0] v, input logic [2:0] m);
        tkse_pkg::plan_t p;
        p = '0;
        p.head[0]  = tkse_pkg::CH_ESC;
        p.head[1]  = tkse_pkg::CH_LBRACK;
        p.head_len = 3'd2;
        p.num_en   = 1'b1;
        p.num_val  = v;
        p.tail[0]  = tkse_pkg::CH_SEMI;
        p.tail[1]  = mod_digit(m);
        p.tail[2]  = tkse_pkg::CH_U;
        p.tail_len = 2'd3;
        return p;
    endfunction

    // UTF-8 bytes of c, with an optional ESC in front.
    function automatic tkse_pkg::plan_t utf8(input logic [20:0] c, input logic alt);
        tkse_pkg::plan_t p;
        logic [3:0][7:0] b;
        logic [2:0] n;
        p = '0;
        b = '0;
        if (c < 21'h80) begin
            b[0] = c[7:0];
            n = 3'd1;
        end else if (c < 21'h800) begin
            b[0] = 8'hC0 | {3'b0, c[10:6]};
            b[1] = 8'h80 | {2'b0, c[5:0]};
            n = 3'd2;
        end else if (c < 21'h10000) begin
            b[0] = 8'hE0 | {4'b0, c[15:12]};
            b[1] = 8'h80 | {2'b0, c[11:6]};
            b[2] = 8'h80 | {2'b0, c[5:0]};
            n = 3'd3;
        end else begin
            b[0] = 8'hF0 | {5'b0, c[20:18]};
            b[1] = 8'h80 | {2'b0, c[17:12]};
            b[2] = 8'h80 | {2'b0, c[11:6]};
            b[3] = 8'h80 | {2'b0, c[5:0]};
            n = 3'd4;
        end
        if (alt) begin
            p.head[0] = tkse_pkg::CH_ESC;
            p.head[1] = b[0];
            p.head[2] = b[1];
            p.head[3] = b[2];
            p.head[4] = b[3];
            p.head_len = n + 3'd1;
        end else begin
            p.head[0] = b[0];
            p.head[1] = b[1];
            p.head[2] = b[2];
            p.head[3] = b[3];
            p.head_len = n;
        end
        return p;
    endfunction

    function automatic tkse_pkg::plan_t key_literal(input logic [7:0] ch, input logic [2:0] m);
        tkse_pkg::plan_t p;
        p = '0;
        if (m[0] || m[2]) begin
            p = csi_u({13'b0, ch}, m);
        end else if (m[1]) begin
            p.head[0]  = tkse_pkg::CH_ESC;
            p.head[1]  = ch;
            p.head_len = 3'd2;
        end else begin
            p.head[0]  = ch;
            p.head_len = 3'd1;
        end
        return p;
    endfunction

    // ESC [ ch, or ESC [ 1 ; mod+1 ch with modifiers.
    function automatic tkse_pkg::plan_t key_csi(input logic [7:0] ch, input logic [2:0] m);
        tkse_pkg::plan_t p;
        p = '0;
        p.head[0] = tkse_pkg::CH_ESC;
        p.head[1] = tkse_pkg::CH_LBRACK;
        if (m != 3'd0) begin
            p.head_len = 3'd2;
            p.num_en   = 1'b1;
            p.num_val  = 21'd1;
            p.tail[0]  = tkse_pkg::CH_SEMI;
            p.tail[1]  = mod_digit(m);
            p.tail[2]  = ch;
            p.tail_len = 2'd3;
        end else begin
            p.head[2]  = ch;
            p.head_len = 3'd3;
        end
        return p;
    endfunction

    function automatic tkse_pkg::plan_t key_ss3(input logic [7:0] ch, input logic [2:0] m);
        tkse_pkg::plan_t p;
        p = '0;
        if (m == 3'd0) begin
            p.head[0]  = tkse_pkg::CH_ESC;
            p.head[1]  = tkse_pkg::CH_O;
            p.head[2]  = ch;
            p.head_len = 3'd3;
        end else begin
            p = key_csi(ch, m);
        end
        return p;
    endfunction

    tkse_pkg::plan_t    p;
    tkse_pkg::key_entry_t ke;
    logic [2:0]         cm;
    logic               csiu;
    logic [20:0]        cc;
    logic [2:0]         top;

    always_comb begin
        p    = '0;
        ke   = tkse_pkg::key_lookup(key_code);
        cm   = modifier;
        csiu = 1'b0;
        cc   = code_point;
        unique case (req_type)
            tkse_pkg::REQ_CHAR: begin
                // Shift only counts on space.
                if (code_point != 21'h20) begin
                    cm[0] = 1'b0;
                end
                if (cm == 3'd0) begin
                    p = utf8(code_point, 1'b0);
                end else begin
                    if (code_point == 21'h69 || code_point == 21'h6A ||
                        code_point == 21'h6D || code_point == 21'h5B) begin
                        csiu = 1'b1;
                    end else if (code_point == 21'h5C || code_point == 21'h5D ||
                                 code_point == 21'h5E || code_point == 21'h5F) begin
                        csiu = 1'b0;
                    end else if (code_point == 21'h20) begin
                        csiu = cm[0];
                    end else begin
                        csiu = (code_point < 21'h61) || (code_point > 21'h7A);
                    end
                    if (csiu && (cm[0] || cm[2])) begin
                        p = csi_u(code_point, cm);
                    end else begin
                        if (cm[2]) begin
                            cc = code_point & tkse_pkg::CTRL_MASK;
                        end
                        p = utf8(cc, cm[1]);
                    end
                end
            end
            tkse_pkg::REQ_KEY: begin
                if (key_code >= tkse_pkg::KEYPAD_FIRST && key_code <= tkse_pkg::KEYPAD_LAST) begin
                    if (cfg.keypad_app) begin
                        p = key_ss3(tkse_pkg::keypad_char(key_code, 1'b1), modifier);
                    end else begin
                        p = key_literal(tkse_pkg::keypad_char(key_code, 1'b0), modifier);
                    end
                end else begin
                    unique case (ke.kind)
                        tkse_pkg::KIND_TAB: begin
                            if (modifier == 3'd1) begin
                                p.head[0]  = tkse_pkg::CH_ESC;
                                p.head[1]  = tkse_pkg::CH_LBRACK;
                                p.head[2]  = tkse_pkg::CH_Z;
                                p.head_len = 3'd3;
                            end else if (modifier[0]) begin
                                p = key_csi(tkse_pkg::CH_Z, modifier);
                            end else begin
                                p = key_literal(ke.ch, modifier);
                            end
                        end
                        tkse_pkg::KIND_ENTER: begin
                            if (cfg.newline) begin
                                p.head[0]  = tkse_pkg::CH_CR;
                                p.head[1]  = tkse_pkg::CH_LF;
                                p.head_len = 3'd2;
                            end else begin
                                p = key_literal(ke.ch, modifier);
                            end
                        end
                        tkse_pkg::KIND_LIT: p = key_literal(ke.ch, modifier);
                        tkse_pkg::KIND_SS3: p = key_ss3(ke.ch, modifier);
                        tkse_pkg::KIND_CSINUM: begin
                            p.head[0]  = tkse_pkg::CH_ESC;
                            p.head[1]  = tkse_pkg::CH_LBRACK;
                            p.head_len = 3'd2;
                            p.num_en   = 1'b1;
                            p.num_val  = {13'b0, ke.num};
                            if (modifier != 3'd0) begin
                                p.tail[0]  = tkse_pkg::CH_SEMI;
                                p.tail[1]  = mod_digit(modifier);
                                p.tail[2]  = ke.ch;
                                p.tail_len = 2'd3;
                            end else begin
                                p.tail[0]  = ke.ch;
                                p.tail_len = 2'd1;
                            end
                        end
                        tkse_pkg::KIND_CURSOR: begin
                            if (cfg.cursor_app) begin
                                p = key_ss3(ke.ch, modifier);
                            end else begin
                                p = key_csi(ke.ch, modifier);
                            end
                        end
                        default: p = '0;
                    endcase
                end
            end
            tkse_pkg::REQ_PASTE_START, tkse_pkg::REQ_PASTE_END: begin
                if (cfg.bracketed) begin
                    p.head[0]  = tkse_pkg::CH_ESC;
                    p.head[1]  = tkse_pkg::CH_LBRACK;
                    p.head_len = 3'd2;
                    p.num_en   = 1'b1;
                    p.num_val  = (req_type == tkse_pkg::REQ_PASTE_START) ? 21'd200 : 21'd201;
                    p.tail[0]  = tkse_pkg::CH_TILDE;
                    p.tail_len = 2'd1;
                end
            end
        endcase
    end

    // Place of the leading decimal digit.
    always_comb begin
        top = 3'd0;
        for (int k = 1; k < tkse_pkg::DEC_DIGITS; k++) begin
            if ({3'b0, p.num_val} >= tkse_pkg::DEC_THRESH[k][0]) begin
                top = top + 3'd1;
            end
        end
    end

    always_comb begin
        plan = p;
        plan.num_top = p.num_en ? top : 3'd0;
    end

endmodule

/* sv/tkse_serializer.sv */
// Result register holding one byte plan, sent a byte per cycle while out_ready is high.
module tkse_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  tkse_pkg::plan_t plan_in,
    output logic            busy,
    output logic            done,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            last_byte
);

    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_NUM  = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;

    logic            busy_reg;
    logic [1:0]      phase_reg, phase_next;
    logic [2:0]      idx_reg, idx_next;
    tkse_pkg::plan_t plan_reg;
    logic [20:0]     rem_reg;

    logic [8:0]      ge;
    logic [3:0]      digit;
    logic [23:0]     sub;
    logic            is_last;
    logic            fire;
    logic [1:0]      start_phase;
    logic [2:0]      start_idx;

    // Leading digit of the remainder at the current decimal place.
    always_comb begin
        sub   = 24'd0;
        digit = 4'd0;
        for (int d = 0; d < 9; d++) begin
            ge[d] = {3'b0, rem_reg} >= tkse_pkg::DEC_THRESH[idx_reg][d];
            if (ge[d]) begin
                sub   = tkse_pkg::DEC_THRESH[idx_reg][d];
                digit = 4'(d + 1);
            end
        end
    end

    always_comb begin
        out_byte = 8'h00;
        is_last  = 1'b0;
        unique case (phase_reg)
            PH_HEAD: begin
                out_byte = plan_reg.head[idx_reg];
                is_last  = (idx_reg == plan_reg.head_len - 3'd1) && !plan_reg.num_en &&
                           (plan_reg.tail_len == 2'd0);
            end
            PH_NUM: begin
                out_byte = tkse_pkg::CH_ZERO + {4'b0, digit};
                is_last  = (idx_reg == 3'd0) && (plan_reg.tail_len == 2'd0);
            end
            PH_TAIL: begin
                out_byte = plan_reg.tail[idx_reg[1:0]];
                is_last  = (idx_reg[1:0] == plan_reg.tail_len - 2'd1);
            end
            default: begin
                out_byte = 8'h00;
                is_last  = 1'b0;
            end
        endcase
    end

    assign busy      = busy_reg;
    assign out_valid = busy_reg;
    assign last_byte = is_last;
    assign fire      = busy_reg && out_ready;
    assign done      = fire && is_last;

    always_comb begin
        if (plan_in.head_len != 3'd0) begin
            start_phase = PH_HEAD;
            start_idx   = 3'd0;
        end else if (plan_in.num_en) begin
            start_phase = PH_NUM;
            start_idx   = plan_in.num_top;
        end else begin
            start_phase = PH_TAIL;
            start_idx   = 3'd0;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        unique case (phase_reg)
            PH_HEAD: begin
                if (idx_reg == plan_reg.head_len - 3'd1) begin
                    if (plan_reg.num_en) begin
                        phase_next = PH_NUM;
                        idx_next   = plan_reg.num_top;
                    end else begin
                        phase_next = PH_TAIL;
                        idx_next   = 3'd0;
                    end
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_NUM: begin
                if (idx_reg == 3'd0) begin
                    phase_next = PH_TAIL;
                end else begin
                    idx_next = idx_reg - 3'd1;
                end
            end
            PH_TAIL: idx_next = idx_reg + 3'd1;
            default: begin
                phase_next = PH_HEAD;
                idx_next   = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_HEAD;
            idx_reg   <= 3'd0;
        end else if (load) begin
            busy_reg  <= 1'b1;
            phase_reg <= start_phase;
            idx_reg   <= start_idx;
        end else if (done) begin
            busy_reg  <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            plan_reg <= plan_in;
            rem_reg  <= plan_in.num_val;
        end else if (fire && phase_reg == PH_NUM) begin
            rem_reg  <= rem_reg - sub[20:0];
        end
    end

endmodule

/* sv/terminal_key_sequence_encoder_top.sv */
// Top level of the terminal key sequence encoder: input register, encoder and byte output.
//
// Each accepted event word is turned into the bytes a VT/xterm terminal sends to the
// host and delivered one byte per output word, with last_byte set on the final byte.
// An event of n bytes (one to twelve) holds the output until its last byte, one byte per
// cycle while out_ready stays high; events that produce nothing (unused keys, paste
// markers outside bracketed-paste mode) are dropped in the cycle after acceptance.
// The byte rate is set by the output register, which sends a head of literal bytes,
// then an optional decimal number one digit per cycle, then a tail of literal bytes.
// An event enters the input register and is encoded while the previous event's bytes
// are still going out, so consecutive events leave no gap on the output. Each event
// passes the input register, then the output register. Configuration is written
// through cfg_we, cfg_index and cfg_data and should change only while the block is idle.
module terminal_key_sequence_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [20:0] code_point,
    input  logic [5:0]  key_code,
    input  logic [2:0]  modifier,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);

    tkse_pkg::cfg_t  cfg_reg;

    // Input register: one event word waiting to be encoded.
    logic            in_full_reg;
    logic [1:0]      req_type_reg;
    logic [20:0]     code_point_reg;
    logic [5:0]      key_code_reg;
    logic [2:0]      modifier_reg;

    tkse_pkg::plan_t plan;
    logic            plan_empty;
    logic            ser_busy;
    logic            ser_done;
    logic            can_load;
    logic            consume;
    logic            load;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tkse_pkg::CFG_NEWLINE: cfg_reg.newline    <= cfg_data;
                tkse_pkg::CFG_CURSOR:  cfg_reg.cursor_app <= cfg_data;
                tkse_pkg::CFG_KEYPAD:  cfg_reg.keypad_app <= cfg_data;
                tkse_pkg::CFG_BRACKET: cfg_reg.bracketed  <= cfg_data;
            endcase
        end
    end

    tkse_encoder u_encoder (
        .req_type   (req_type_reg),
        .code_point (code_point_reg),
        .key_code   (key_code_reg),
        .modifier   (modifier_reg),
        .cfg        (cfg_reg),
        .plan       (plan)
    );

    assign plan_empty = (plan.head_len == 3'd0) && !plan.num_en && (plan.tail_len == 2'd0);

    // The output register can take a new plan when it is empty or sends its last byte now.
    assign can_load = !ser_busy || ser_done;
    assign consume  = in_full_reg && (plan_empty || can_load);
    assign load     = in_full_reg && !plan_empty && can_load;
    assign in_ready = !in_full_reg || consume;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
        end else if (in_ready) begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            req_type_reg   <= req_type;
            code_point_reg <= code_point;
            key_code_reg   <= key_code;
            modifier_reg   <= modifier;
        end
    end

    tkse_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .plan_in   (plan),
        .busy      (ser_busy),
        .done      (ser_done),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

/* tb/terminal_key_sequence_encoder_top_tb.sv */
// Self-checking testbench for the terminal key sequence encoder with random handshake traffic.
module terminal_key_sequence_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tkse_pkg::*;

    // Modifier bits of an event word.
    localparam logic [2:0] MOD_NONE  = 3'b000;
    localparam logic [2:0] MOD_SHIFT = 3'b001;
    localparam logic [2:0] MOD_ALT   = 3'b010;
    localparam logic [2:0] MOD_CTRL  = 3'b100;
    localparam logic [2:0] MOD_ALL   = 3'b111;

    // Key codes used by the directed tests.
    localparam logic [5:0] KEY_NONE     = 6'd0;
    localparam logic [5:0] KEY_ENTER    = 6'd1;
    localparam logic [5:0] KEY_TAB      = 6'd2;
    localparam logic [5:0] KEY_UP       = 6'd5;
    localparam logic [5:0] KEY_F0       = 6'd15;
    localparam logic [5:0] KEY_F1       = 6'd16;
    localparam logic [5:0] KEY_F12      = 6'd27;
    localparam logic [5:0] KEY_KP_0     = 6'd28;
    localparam logic [5:0] KEY_KP_ENTER = 6'd44;
    localparam logic [5:0] KEY_KP_EQUAL = 6'd45;
    localparam logic [5:0] KEY_TOP      = 6'd63;

    // Longest sequence of one event, in bytes.
    localparam int MAX_SEQ_BYTES = 12;
    // Cycles allowed after the last byte for a silent event to leave the pipeline.
    localparam int DRAIN_TAIL = 8;
    // Cycles with no word moving on either side before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Length of the long receiver hold-off in the backpressure test.
    localparam int LONG_HOLD = 150;

    // Editing and function keys, indexed by key code 0 to 27: form, final byte, number.
    localparam logic [2:0] KEY_FORM [28] = '{
        KIND_NONE, KIND_ENTER, KIND_TAB, KIND_LIT, KIND_LIT,
        KIND_CURSOR, KIND_CURSOR, KIND_CURSOR, KIND_CURSOR,
        KIND_CSINUM, KIND_CSINUM, KIND_CURSOR, KIND_CURSOR, KIND_CSINUM, KIND_CSINUM,
        KIND_NONE, KIND_SS3, KIND_SS3, KIND_SS3, KIND_SS3,
        KIND_CSINUM, KIND_CSINUM, KIND_CSINUM, KIND_CSINUM,
        KIND_CSINUM, KIND_CSINUM, KIND_CSINUM, KIND_CSINUM
    };
    localparam logic [7:0] KEY_FINAL [28] = '{
        8'h00, 8'h0D, 8'h09, 8'h7F, 8'h1B, 8'h41, 8'h42, 8'h44, 8'h43,
        8'h7E, 8'h7E, 8'h48, 8'h46, 8'h7E, 8'h7E, 8'h00,
        8'h50, 8'h51, 8'h52, 8'h53,
        8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'h7E
    };
    localparam int KEY_NUMBER [28] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 2, 3, 0, 0, 5, 6,
        0, 0, 0, 0, 0, 15, 17, 18, 19, 20, 21, 23, 24
    };

    // Keypad keys: numeric bytes and application (SS3) bytes.
    localparam logic [7:0] KP_NUMERIC [18] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h0A, 8'h3D
    };
    localparam logic [7:0] KP_APPLICATION [18] = '{
        8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79,
        8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h4D, 8'h58
    };

    // One byte on its way to the host, with its end-of-sequence flag.
    typedef struct {
        logic [7:0] value;
        logic       last;
    } host_byte_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [20:0] code_point;
    logic [5:0]  key_code;
    logic [2:0]  modifier;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        last_byte;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic        cfg_data;

    // Copy of the mode registers as the block should hold them.
    cfg_t        modes;
    // Bytes of the event being encoded, and the bytes the host still has to receive.
    logic [7:0]  event_bytes [$];
    host_byte_t  host_bytes_due [$];

    int          mismatch_count;
    int unsigned quiet_cycles;
    // Set by a test to make the host side hold off taking bytes for a stretch set by its value.
    int          rx_hold_request;
    // While set, neither side inserts idle cycles.
    logic        steady_traffic;

    terminal_key_sequence_encoder_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .code_point (code_point),
        .key_code   (key_code),
        .modifier   (modifier),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last_byte  (last_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Sequence predictor. Each helper appends to event_bytes; the cap
    // mirrors the block's twelve-byte limit, which no event goes past.
    // ------------------------------------------------------------------
    function automatic void emit(input int unsigned b);
        if (event_bytes.size() < MAX_SEQ_BYTES)
            event_bytes.push_back(b[7:0]);
    endfunction

    // Decimal digits, most significant first.
    function automatic void emit_dec(input int unsigned v);
        int unsigned digits [$];
        do
        begin
            digits.push_front(v % 10);
            v = v / 10;
        end
        while (v != 0);
        foreach (digits[i])
            emit(CH_ZERO + digits[i]);
    endfunction

    // Plain UTF-8 bit pattern; values past the Unicode range still get four bytes.
    function automatic void emit_utf8(input int unsigned c);
        if (c < 32'h80)
        begin
            emit(c);
        end
        else if (c < 32'h800)
        begin
            emit(32'hC0 | (c >> 6));
            emit(32'h80 | (c & 32'h3F));
        end
        else if (c < 32'h10000)
        begin
            emit(32'hE0 | (c >> 12));
            emit(32'h80 | ((c >> 6) & 32'h3F));
            emit(32'h80 | (c & 32'h3F));
        end
        else
        begin
            emit(32'hF0 | ((c >> 18) & 32'h07));
            emit(32'h80 | ((c >> 12) & 32'h3F));
            emit(32'h80 | ((c >> 6) & 32'h3F));
            emit(32'h80 | (c & 32'h3F));
        end
    endfunction

    // ESC [ code ; mod+1 u
    function automatic void emit_csi_u(input int unsigned c, input int unsigned m);
        emit(CH_ESC);
        emit(CH_LBRACK);
        emit_dec(c);
        emit(CH_SEMI);
        emit_dec(m + 1);
        emit(CH_U);
    endfunction

    function automatic void key_literal(input logic [7:0] ch, input int unsigned m);
        if ((m & (MOD_SHIFT | MOD_CTRL)) != 0)
        begin
            emit_csi_u(ch, m);
        end
        else
        begin
            if ((m & MOD_ALT) != 0)
                emit(CH_ESC);
            emit(ch);
        end
    endfunction

    function automatic void key_csi(input logic [7:0] ch, input int unsigned m);
        emit(CH_ESC);
        emit(CH_LBRACK);
        if (m != 0)
        begin
            emit(CH_ONE);
            emit(CH_SEMI);
            emit_dec(m + 1);
        end
        emit(ch);
    endfunction

    // SS3 form only without modifiers; modified keys fall back to CSI 1;m.
    function automatic void key_ss3(input logic [7:0] ch, input int unsigned m);
        if (m == 0)
        begin
            emit(CH_ESC);
            emit(CH_O);
            emit(ch);
        end
        else
        begin
            key_csi(ch, m);
        end
    endfunction

    function automatic void encode_event(input logic [1:0] kind, input logic [20:0] cp,
                                         input logic [5:0] key, input logic [2:0] mods);
        int unsigned c;
        int unsigned m;
        int unsigned slot;
        logic        csiu;
        event_bytes.delete();
        c = cp;
        m = mods;
        case (kind)
            REQ_CHAR:
            begin
                // Shift only matters on the space bar.
                if (c != " ")
                    m = m & ~32'(MOD_SHIFT);
                if (m == 0)
                begin
                    emit_utf8(c);
                end
                else
                begin
                    if (c == "i" || c == "j" || c == "m" || c == "[")
                        csiu = 1'b1;
                    else if (c == "\\" || c == "]" || c == "^" || c == "_")
                        csiu = 1'b0;
                    else if (c == " ")
                        csiu = (m & MOD_SHIFT) != 0;
                    else
                        csiu = (c < "a" || c > "z");
                    // Alt alone never needs CSI-u: it is just an ESC prefix.
                    if (csiu && (m & ~32'(MOD_ALT)) != 0)
                    begin
                        emit_csi_u(c, m);
                    end
                    else
                    begin
                        if ((m & MOD_CTRL) != 0)
                            c = c & CTRL_MASK;
                        if ((m & MOD_ALT) != 0)
                            emit(CH_ESC);
                        emit_utf8(c);
                    end
                end
            end
            REQ_KEY:
            begin
                if (key < KEYPAD_FIRST)
                begin
                    case (KEY_FORM[key])
                        KIND_TAB:
                        begin
                            if (m == MOD_SHIFT)
                            begin
                                emit(CH_ESC);
                                emit(CH_LBRACK);
                                emit(CH_Z);
                            end
                            else if ((m & MOD_SHIFT) != 0)
                            begin
                                emit(CH_ESC);
                                emit(CH_LBRACK);
                                emit(CH_ONE);
                                emit(CH_SEMI);
                                emit_dec(m + 1);
                                emit(CH_Z);
                            end
                            else
                            begin
                                key_literal(KEY_FINAL[key], m);
                            end
                        end
                        KIND_ENTER:
                        begin
                            if (modes.newline)
                            begin
                                emit(CH_CR);
                                emit(CH_LF);
                            end
                            else
                            begin
                                key_literal(KEY_FINAL[key], m);
                            end
                        end
                        KIND_LIT:
                            key_literal(KEY_FINAL[key], m);
                        KIND_SS3:
                            key_ss3(KEY_FINAL[key], m);
                        KIND_CSINUM:
                        begin
                            emit(CH_ESC);
                            emit(CH_LBRACK);
                            emit_dec(KEY_NUMBER[key]);
                            if (m != 0)
                            begin
                                emit(CH_SEMI);
                                emit_dec(m + 1);
                            end
                            emit(KEY_FINAL[key]);
                        end
                        KIND_CURSOR:
                        begin
                            if (modes.cursor_app)
                                key_ss3(KEY_FINAL[key], m);
                            else
                                key_csi(KEY_FINAL[key], m);
                        end
                        default:
                            ;
                    endcase
                end
                else if (key <= KEYPAD_LAST)
                begin
                    slot = key - KEYPAD_FIRST;
                    if (modes.keypad_app)
                        key_ss3(KP_APPLICATION[slot], m);
                    else
                        key_literal(KP_NUMERIC[slot], m);
                end
            end
            default:
            begin
                // Paste markers ESC [ 200 ~ and ESC [ 201 ~, only when enabled.
                if (modes.bracketed)
                begin
                    emit(CH_ESC);
                    emit(CH_LBRACK);
                    emit(CH_ZERO + 8'd2);
                    emit(CH_ZERO);
                    emit(kind == REQ_PASTE_START ? CH_ZERO : CH_ONE);
                    emit(CH_TILDE);
                end
            end
        endcase
    endfunction

    // Idle stretch length: mostly short, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Event side. Tasks are entered and left in the time step of a rising
    // edge, so every drive below is a single nonblocking update per step.
    // ------------------------------------------------------------------

    // Offers one event word, waits for it to be taken, and records the bytes it must
    // produce. in_valid is left high so a following word can go out back to back.
    task automatic send_event(input logic [1:0] kind, input logic [20:0] cp,
                              input logic [5:0] key, input logic [2:0] mods);
        host_byte_t due;
        in_valid   <= 1'b1;
        req_type   <= kind;
        code_point <= cp;
        key_code   <= key;
        modifier   <= mods;
        do
            @(posedge clk);
        while (!in_ready);
        encode_event(kind, cp, key, mods);
        foreach (event_bytes[i])
        begin
            due.value = event_bytes[i];
            due.last  = (i == event_bytes.size() - 1);
            host_bytes_due.push_back(due);
        end
    endtask

    // Random gap between event words, skipped half the time and while traffic is steady.
    task automatic pause_sender();
        if (!steady_traffic && $urandom_range(0, 1) == 1)
        begin
            in_valid <= 1'b0;
            repeat (idle_length()) @(posedge clk);
        end
    endtask

    // Stop offering words and wait until the host has every expected byte. Events that
    // produce nothing may still sit in the pipeline, so the task then also waits out DRAIN_TAIL.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (host_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // Writes all four mode registers, one per cycle, once the block is idle.
    task automatic write_modes(input cfg_t m);
        logic bit_value;
        wait_drained();
        for (int i = 0; i < 4; i++)
        begin
            case (2'(i))
                CFG_NEWLINE: bit_value = m.newline;
                CFG_CURSOR:  bit_value = m.cursor_app;
                CFG_KEYPAD:  bit_value = m.keypad_app;
                default:     bit_value = m.bracketed;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= bit_value;
            @(posedge clk);
            case (2'(i))
                CFG_NEWLINE: modes.newline    = bit_value;
                CFG_CURSOR:  modes.cursor_app = bit_value;
                CFG_KEYPAD:  modes.keypad_app = bit_value;
                default:     modes.bracketed  = bit_value;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Character events in reset modes: UTF-8 lengths, out-of-range code points,
    // Ctrl masking, the Alt prefix, CSI-u and the shift rule. Unused fields are random.
    task automatic test_char_encoding();
        send_event(REQ_CHAR, 21'h000000, 6'($urandom), MOD_NONE);
        pause_sender();
        // Largest code point with every modifier gives the longest CSI-u sequence.
        send_event(REQ_CHAR, 21'h1FFFFF, 6'($urandom), MOD_ALL);
        pause_sender();
        send_event(REQ_CHAR, 21'h1FFFFF, 6'($urandom), MOD_NONE);
        pause_sender();
        // Surrogate half goes out as a plain three-byte pattern.
        send_event(REQ_CHAR, 21'h00D800, 6'($urandom), MOD_NONE);
        pause_sender();
        send_event(REQ_CHAR, 21'h0007FF, 6'($urandom), MOD_ALT);
        pause_sender();
        send_event(REQ_CHAR, 21'h010000, 6'($urandom), MOD_NONE);
        pause_sender();
        // Shift survives on space only.
        send_event(REQ_CHAR, 21'(" "), 6'($urandom), MOD_SHIFT);
        pause_sender();
        send_event(REQ_CHAR, 21'("A"), 6'($urandom), MOD_SHIFT);
        pause_sender();
        send_event(REQ_CHAR, 21'("c"), 6'($urandom), MOD_CTRL | MOD_ALT);
        pause_sender();
        send_event(REQ_CHAR, 21'("i"), 6'($urandom), MOD_CTRL);
        pause_sender();
        send_event(REQ_CHAR, 21'("\\"), 6'($urandom), MOD_CTRL);
        pause_sender();
    endtask

    // Named keys in reset modes, including codes that produce nothing and paste
    // markers while bracketed paste is off.
    task automatic test_named_keys();
        send_event(REQ_KEY, 21'($urandom), KEY_NONE, MOD_NONE);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_F0, MOD_ALL);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_TOP, MOD_NONE);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_ENTER, MOD_NONE);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_TAB, MOD_SHIFT);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_TAB, MOD_SHIFT | MOD_CTRL);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_UP, MOD_NONE);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_F1, MOD_NONE);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_F12, MOD_ALL);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_KP_0, MOD_NONE);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_KP_EQUAL, MOD_ALL);
        pause_sender();
        send_event(REQ_PASTE_START, 21'($urandom), 6'($urandom), 3'($urandom));
        pause_sender();
        send_event(REQ_PASTE_END, 21'($urandom), 6'($urandom), 3'($urandom));
    endtask

    // Every mode set: Enter gives CR LF even with modifiers, cursor and keypad keys
    // switch to SS3, and the paste markers appear.
    task automatic test_mode_registers();
        write_modes('1);
        send_event(REQ_KEY, 21'($urandom), KEY_ENTER, MOD_ALL);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_UP, MOD_NONE);
        pause_sender();
        send_event(REQ_KEY, 21'($urandom), KEY_KP_ENTER, MOD_NONE);
        pause_sender();
        send_event(REQ_PASTE_START, 21'($urandom), 6'($urandom), 3'($urandom));
        pause_sender();
        send_event(REQ_PASTE_END, 21'($urandom), 6'($urandom), 3'($urandom));
    endtask

    // The host stops taking bytes for a long stretch while words keep coming, so the
    // block must fill up and hold off its input; afterwards the sender waits for
    // every byte to arrive before going on.
    task automatic test_backpressure();
        rx_hold_request = LONG_HOLD;
        repeat (20)
            send_event(REQ_CHAR, 21'h1FFFFF - 21'($urandom_range(0, 1000)),
                       6'($urandom), MOD_CTRL);
        wait_drained();
    endtask

    // Random traffic over several mode settings: all clear, all set, then random.
    // One phase runs with no idle cycles on either side.
    task automatic test_random_traffic();
        cfg_t        m;
        int unsigned pick;
        logic [1:0]  kind;
        logic [20:0] cp;
        logic [5:0]  key;
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                m = '0;
            else if (phase == 1)
                m = '1;
            else
                m = cfg_t'(4'($urandom));
            write_modes(m);
            steady_traffic = (phase == 4);
            repeat (19)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    kind = REQ_CHAR;
                else if (pick < 18)
                    kind = REQ_KEY;
                else if (pick == 18)
                    kind = REQ_PASTE_START;
                else
                    kind = REQ_PASTE_END;
                // Spread code points over every UTF-8 length and past the Unicode range.
                case ($urandom_range(0, 6))
                    0, 1:    cp = 21'($urandom_range(0, 127));
                    2:       cp = 21'($urandom_range(32'h80, 32'h7FF));
                    3:       cp = 21'($urandom_range(32'h800, 32'hFFFF));
                    4:       cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
                    5:       cp = 21'(" ");
                    default: cp = 21'($urandom);
                endcase
                if ($urandom_range(0, 9) < 7)
                    key = 6'($urandom_range(1, 45));
                else
                    key = 6'($urandom);
                send_event(kind, cp, key, 3'($urandom));
                pause_sender();
            end
            steady_traffic = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Host side: takes bytes with random stalls, or holds off on request.
    // ------------------------------------------------------------------
    initial
    begin : host_side
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_request != 0)
            begin
                stall_left = rx_hold_request;
                rx_hold_request = 0;
            end
            else if (stall_left == 0 && !steady_traffic && $urandom_range(0, 99) < 25)
            begin
                stall_left = idle_length();
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Every byte word taken by the host is compared with the oldest expected byte.
    always @(posedge clk)
    begin : check_bytes
        host_byte_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (host_bytes_due.size() == 0)
            begin
                $error("unexpected byte word: out_byte %h last_byte %b", out_byte, last_byte);
                mismatch_count++;
            end
            else
            begin
                due = host_bytes_due.pop_front();
                if (out_byte !== due.value)
                begin
                    $error("out_byte: expected %h, actual %h", due.value, out_byte);
                    mismatch_count++;
                end
                if (last_byte !== due.last)
                begin
                    $error("last_byte: expected %b, actual %b", due.last, last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // Counts cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        mismatch_count  = 0;
        rx_hold_request = 0;
        steady_traffic  = 1'b0;
        modes           = '0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= REQ_CHAR;
        code_point <= '0;
        key_code   <= KEY_NONE;
        modifier   <= MOD_NONE;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_NEWLINE;
        cfg_data   <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_char_encoding();
        test_named_keys();
        test_mode_registers();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
